// File: sv/srpd_pkg.sv
// Shared types and constants for the Sun raster pixel decoder.
// No dependencies.
`timescale 1ns / 1ps
package srpd_pkg;
    localparam logic [31:0] RAS_MAGIC = 32'h59a66a95;
    localparam logic [31:0] DIM_MAX   = 32'h7fffffff;
    localparam logic [31:0] MAP_FULL  = 32'd768;

    localparam logic [1:0] ST_PIXEL   = 2'd0;
    localparam logic [1:0] ST_MAGIC   = 2'd1;
    localparam logic [1:0] ST_DIMS    = 2'd2;
    localparam logic [1:0] ST_DEPTH   = 2'd3;

    // Command from the front part to the back part.
    typedef struct packed {
        logic        is_err;
        logic [1:0]  status;
        logic        use_pal;
        logic [7:0]  data;
        logic [30:0] column;
        logic [30:0] row;
        logic        last;
    } t_cmd;
endpackage

// File: sv/srpd_front.sv
// Front part: parses header, map and row position, and drives the palette writes.
// Depends on srpd_pkg.
`timescale 1ns / 1ps
module srpd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data_byte,
    input  logic            i_start_of_file,
    output logic            o_stall,
    output logic            o_cmd_valid,
    output srpd_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_stall,
    output logic            o_pal_we,
    output logic [9:0]      o_pal_waddr,
    output logic [7:0]      o_pal_wdata
);
    localparam logic [1:0] PH_IDLE = 2'd0, PH_HEADER = 2'd1, PH_MAP = 2'd2,
                           PH_PIXEL = 2'd3;

    logic [1:0]  r_phase;
    logic [4:0]  r_hcnt;
    logic [31:0] r_word, r_width, r_height, r_dlen, r_depth, r_mkind, r_mlen, r_mleft;
    logic [30:0] r_col, r_row;
    logic        r_pad;

    logic        w_acc;
    logic [1:0]  w_ph;
    logic [4:0]  w_hc, w_hn;
    logic [31:0] w_wa, w_wn;
    logic [31:0] w_col1, w_row1;

    assign o_stall = i_cmd_stall;
    assign w_acc   = i_valid && !i_cmd_stall;
    assign w_ph    = i_start_of_file ? PH_HEADER : r_phase;
    assign w_hc    = i_start_of_file ? 5'd0 : r_hcnt;
    assign w_wa    = i_start_of_file ? 32'd0 : r_word;
    assign w_hn    = w_hc + 5'd1;
    assign w_wn    = {w_wa[23:0], i_data_byte};
    assign w_col1  = {1'b0, r_col} + 32'd1;
    assign w_row1  = {1'b0, r_row} + 32'd1;

    always_comb begin
        o_cmd_valid = 1'b0;
        o_cmd = '0;
        o_cmd.data = i_data_byte;
        o_cmd.column = r_col;
        o_cmd.row = r_row;
        o_cmd.use_pal = (r_mkind != 32'd0) && (r_mlen == srpd_pkg::MAP_FULL);
        o_cmd.last = (w_col1 == r_width) && (w_row1 == r_height);
        o_pal_we = 1'b0;
        o_pal_waddr = 10'(srpd_pkg::MAP_FULL - r_mleft);
        o_pal_wdata = i_data_byte;
        if (i_valid) begin
            case (w_ph)
                PH_HEADER: begin
                    if (w_hn == 5'd4 && w_wn != srpd_pkg::RAS_MAGIC) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.is_err = 1'b1;
                        o_cmd.status = srpd_pkg::ST_MAGIC;
                    end else if (w_hn == 5'd0) begin
                        if (r_width == 0 || r_height == 0 || r_width > srpd_pkg::DIM_MAX ||
                            r_height > srpd_pkg::DIM_MAX || r_dlen > srpd_pkg::DIM_MAX) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.is_err = 1'b1;
                            o_cmd.status = srpd_pkg::ST_DIMS;
                        end else if (r_depth != 32 && r_depth != 24 && r_depth != 8 &&
                                     r_depth != 4 && r_depth != 1) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.is_err = 1'b1;
                            o_cmd.status = srpd_pkg::ST_DEPTH;
                        end
                    end
                end
                PH_MAP: o_pal_we = w_acc && (r_mlen == srpd_pkg::MAP_FULL) &&
                                   (r_mleft != 0) && (r_mleft <= srpd_pkg::MAP_FULL);
                PH_PIXEL: o_cmd_valid = !r_pad;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_hcnt <= '0; r_word <= '0;
            r_width <= '0; r_height <= '0; r_dlen <= '0; r_depth <= '0;
            r_mkind <= '0; r_mlen <= '0; r_mleft <= '0;
            r_col <= '0; r_row <= '0; r_pad <= 1'b0;
        end else if (w_acc) begin
            r_phase <= w_ph;
            case (w_ph)
                PH_HEADER: begin
                    r_word <= w_wn;
                    r_hcnt <= w_hn;
                    case (w_hn)
                        5'd4:  if (w_wn != srpd_pkg::RAS_MAGIC) r_phase <= PH_IDLE;
                        5'd8:  r_width <= w_wn;
                        5'd12: r_height <= w_wn;
                        5'd16: r_depth <= w_wn;
                        5'd20: r_dlen <= w_wn;
                        5'd28: r_mkind <= w_wn;
                        5'd0: begin
                            r_mlen <= w_wn;
                            r_col <= '0; r_row <= '0; r_pad <= 1'b0;
                            if (o_cmd_valid) r_phase <= PH_IDLE;
                            else if (r_mkind != 0 && w_wn != 0) begin
                                r_mleft <= w_wn; r_phase <= PH_MAP;
                            end else begin
                                r_mleft <= '0; r_phase <= PH_PIXEL;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_MAP: begin
                    r_mleft <= r_mleft - 32'd1;
                    if (r_mleft == 32'd1) r_phase <= PH_PIXEL;
                end
                PH_PIXEL: begin
                    if (r_pad) begin
                        r_pad <= 1'b0;
                        if ({1'b0, r_row} >= r_height) r_phase <= PH_IDLE;
                    end else if (w_col1 >= r_width) begin
                        r_col <= '0;
                        r_row <= w_row1[30:0];
                        if (r_width[0]) r_pad <= 1'b1;
                        else if (w_row1 >= r_height) r_phase <= PH_IDLE;
                    end else begin
                        r_col <= w_col1[30:0];
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// File: sv/srpd_back.sv
// Back part: single-entry command queue, palette memory read and output register.
// Depends on srpd_pkg.
`timescale 1ns / 1ps
module srpd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  srpd_pkg::t_cmd  i_cmd,
    output logic            o_cmd_stall,
    input  logic            i_pal_we,
    input  logic [9:0]      i_pal_waddr,
    input  logic [7:0]      i_pal_wdata,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_status,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic [30:0]     o_column,
    output logic [30:0]     o_row,
    output logic            o_last_pixel
);
    // Three palette planes so R, G and B are read together.
    logic [7:0] r_pr [256];
    logic [7:0] r_pg [256];
    logic [7:0] r_pb [256];

    // Stage 1 holds a command while its palette read is in flight.
    logic           r_s1_v;
    srpd_pkg::t_cmd r_s1;
    logic [7:0]     r_rd_r, r_rd_g, r_rd_b;
    logic           r_out_v;
    logic           w_s1_go, w_in_go;

    assign w_s1_go     = r_s1_v && (!r_out_v || !i_stall);
    assign w_in_go     = i_cmd_valid && (!r_s1_v || w_s1_go);
    assign o_cmd_stall = r_s1_v && !w_s1_go;

    always_ff @(posedge i_clk) begin
        if (i_pal_we) begin
            case (i_pal_waddr[9:8])
                2'd0: r_pr[i_pal_waddr[7:0]] <= i_pal_wdata;
                2'd1: r_pg[i_pal_waddr[7:0]] <= i_pal_wdata;
                2'd2: r_pb[i_pal_waddr[7:0]] <= i_pal_wdata;
                default: ;
            endcase
        end
        if (w_in_go) begin
            r_rd_r <= r_pr[i_cmd.data];
            r_rd_g <= r_pg[i_cmd.data];
            r_rd_b <= r_pb[i_cmd.data];
            r_s1   <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_in_go) r_s1_v <= 1'b1;
            else if (w_s1_go) r_s1_v <= 1'b0;
            if (w_s1_go) r_out_v <= 1'b1;
            else if (!i_stall) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            o_status <= r_s1.status;
            o_column <= r_s1.is_err ? 31'd0 : r_s1.column;
            o_row <= r_s1.is_err ? 31'd0 : r_s1.row;
            o_last_pixel <= r_s1.is_err ? 1'b0 : r_s1.last;
            if (r_s1.is_err) begin
                o_red <= '0; o_green <= '0; o_blue <= '0;
            end else if (r_s1.use_pal) begin
                o_red <= r_rd_r; o_green <= r_rd_g; o_blue <= r_rd_b;
            end else begin
                o_red <= r_s1.data; o_green <= r_s1.data; o_blue <= r_s1.data;
            end
        end
    end
    assign o_valid = r_out_v;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && i_stall |=> r_out_v && $stable(o_row)) else $error("output lost");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && o_status != srpd_pkg::ST_PIXEL |-> o_column == 0 && !o_last_pixel)
        else $error("error word not clean");
    a_s1_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !w_s1_go |=> r_s1_v) else $error("queue entry dropped");
`endif
endmodule

// File: sv/sun_raster_pixel_decoder_unit.sv
// Top level of the Sun raster pixel decoder: front parser plus back queue.
// Depends on srpd_pkg, srpd_front and srpd_back.
`timescale 1ns / 1ps
// Takes one file byte per cycle and gives at most one word per byte: a pixel or
// an error code. Each result passes the registered palette read and then the
// output register; a byte is accepted every cycle unless the output side stalls.
// No clearing pass is needed after reset.
module sun_raster_pixel_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [30:0] o_column,
    output logic [30:0] o_row,
    output logic        o_last_pixel
);
    logic           w_cv, w_cs, w_we;
    srpd_pkg::t_cmd w_cmd;
    logic [9:0]     w_wa;
    logic [7:0]     w_wd;

    srpd_front u_front (.i_clk, .i_rst_n, .i_valid, .i_data_byte, .i_start_of_file,
        .o_stall, .o_cmd_valid(w_cv), .o_cmd(w_cmd), .i_cmd_stall(w_cs),
        .o_pal_we(w_we), .o_pal_waddr(w_wa), .o_pal_wdata(w_wd));

    srpd_back u_back (.i_clk, .i_rst_n, .i_cmd_valid(w_cv), .i_cmd(w_cmd),
        .o_cmd_stall(w_cs), .i_pal_we(w_we), .i_pal_waddr(w_wa), .i_pal_wdata(w_wd),
        .o_valid, .i_stall, .o_status, .o_red, .o_green, .o_blue, .o_column, .o_row,
        .o_last_pixel);
endmodule

// File: bench/testbench.sv
// Self-checking bench for the Sun raster pixel decoder: builds raster files byte
// by byte, predicts each pixel or error word, and checks the block's output.
// Depends on srpd_pkg and sun_raster_pixel_decoder_unit.
`timescale 1ns / 1ps
module testbench;
    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } t_byte;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [30:0] column;
        logic [30:0] row;
        logic        last;
    } t_pix;

    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_MAP, PH_PIXEL} t_phase;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall, i_start_of_file, o_valid, i_stall;
    logic [7:0]  i_data_byte, o_red, o_green, o_blue;
    logic [1:0]  o_status;
    logic [30:0] o_column, o_row;
    logic        o_last_pixel;

    sun_raster_pixel_decoder_unit i_dut (.*);

    // Decoder state kept by the predictor.
    t_phase      dec_phase;
    logic [4:0]  hdr_count;
    logic [31:0] shift_word, img_w, img_h, img_len, img_depth, img_maptype, img_maplen;
    logic [31:0] map_left;
    logic [7:0]  palette [768];
    logic [30:0] col_cnt, row_cnt;
    logic        pad_due;

    t_byte byte_queue[$];
    t_pix  expected_pixels[$];
    int    errors = 0, pixels_seen = 0, files_sent = 0, items_queued = 0;
    bit    quiet_end = 0, sender_pause = 0, in_taken = 0;
    int    gap_left = 0, stall_left = 0, hold_left = 0;

    task automatic push_result(input logic [1:0] st, input logic [7:0] r, g, b,
                               input logic [30:0] c, rw, input logic l);
        t_pix p;
        p.status = st; p.red = r; p.green = g; p.blue = b;
        p.column = c; p.row = rw; p.last = l;
        expected_pixels.push_back(p);
    endtask

    task automatic predict_byte(input t_byte it);
        logic [31:0] w;
        logic [7:0]  r, g, b;
        logic        fin;
        if (it.sof) begin
            dec_phase = PH_HEADER; hdr_count = 0; shift_word = 0;
        end
        case (dec_phase)
            PH_HEADER: begin
                shift_word = {shift_word[23:0], it.data};
                hdr_count = hdr_count + 1;
                w = shift_word;
                if (hdr_count[1:0] == 0) begin
                    case (hdr_count)
                        5'd4: if (w != srpd_pkg::RAS_MAGIC) begin
                            dec_phase = PH_IDLE;
                            push_result(srpd_pkg::ST_MAGIC, 0, 0, 0, 0, 0, 0);
                        end
                        5'd8:  img_w = w;
                        5'd12: img_h = w;
                        5'd16: img_depth = w;
                        5'd20: img_len = w;
                        5'd24: ;
                        5'd28: img_maptype = w;
                        default: begin
                            img_maplen = w;
                            if (img_w == 0 || img_h == 0 || img_w > srpd_pkg::DIM_MAX ||
                                img_h > srpd_pkg::DIM_MAX || img_len > srpd_pkg::DIM_MAX)
                            begin
                                dec_phase = PH_IDLE;
                                push_result(srpd_pkg::ST_DIMS, 0, 0, 0, 0, 0, 0);
                            end else if (!(img_depth inside {32, 24, 8, 4, 1})) begin
                                dec_phase = PH_IDLE;
                                push_result(srpd_pkg::ST_DEPTH, 0, 0, 0, 0, 0, 0);
                            end else begin
                                col_cnt = 0; row_cnt = 0; pad_due = 0;
                                if (img_maptype != 0 && img_maplen != 0) begin
                                    map_left = img_maplen; dec_phase = PH_MAP;
                                end else begin
                                    map_left = 0; dec_phase = PH_PIXEL;
                                end
                            end
                        end
                    endcase
                end
            end
            PH_MAP: begin
                if (img_maplen == srpd_pkg::MAP_FULL)
                    palette[srpd_pkg::MAP_FULL - map_left] = it.data;
                map_left = map_left - 1;
                if (map_left == 0) dec_phase = PH_PIXEL;
            end
            PH_PIXEL: begin
                if (pad_due) begin
                    pad_due = 0;
                    if ({1'b0, row_cnt} >= img_h) dec_phase = PH_IDLE;
                end else begin
                    if (img_maptype != 0 && img_maplen == srpd_pkg::MAP_FULL) begin
                        r = palette[it.data]; g = palette[it.data + 256];
                        b = palette[it.data + 512];
                    end else begin
                        r = it.data; g = it.data; b = it.data;
                    end
                    fin = ({1'b0, col_cnt} + 1 == img_w) && ({1'b0, row_cnt} + 1 == img_h);
                    push_result(srpd_pkg::ST_PIXEL, r, g, b, col_cnt, row_cnt, fin);
                    if ({1'b0, col_cnt} + 1 >= img_w) begin
                        col_cnt = 0; row_cnt = row_cnt + 1;
                        if (img_w[0]) pad_due = 1;
                        else if ({1'b0, row_cnt} >= img_h) dec_phase = PH_IDLE;
                    end else begin
                        col_cnt = col_cnt + 1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic add_byte(input logic [7:0] d, input logic s);
        t_byte it;
        it.data = d; it.sof = s;
        byte_queue.push_back(it);
        items_queued++;
    endtask

    task automatic add_word(input logic [31:0] w, input bit first);
        add_byte(w[31:24], first); add_byte(w[23:16], 0);
        add_byte(w[15:8], 0); add_byte(w[7:0], 0);
    endtask

    // One whole file: header, optional map, pixel bytes with row padding.
    task automatic add_file(input logic [31:0] w, h, dep, len, mtype, mlen,
                            input int npix_bytes);
        add_word(srpd_pkg::RAS_MAGIC, 1); add_word(w, 0); add_word(h, 0);
        add_word(dep, 0); add_word(len, 0); add_word($urandom, 0);
        add_word(mtype, 0); add_word(mlen, 0);
        if (mtype != 0) for (int k = 0; k < mlen; k++) add_byte($urandom, 0);
        for (int k = 0; k < npix_bytes; k++) add_byte($urandom, 0);
        files_sent++;
    endtask

    function automatic logic [31:0] pick_depth();
        case ($urandom_range(0, 4))
            0: return 32; 1: return 24; 2: return 8; 3: return 4;
            default: return 1;
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: items change at the falling edge; acceptance comes from the rising edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0; i_data_byte <= 0; i_start_of_file <= 0;
        end else if (!i_valid || in_taken) begin
            if (in_taken) void'(byte_queue.pop_front());
            if (gap_left > 0) gap_left--;
            else if (!quiet_end && $urandom_range(0, 15) == 0)
                gap_left = $urandom_range(1, 4);
            if (gap_left == 0 && !sender_pause && byte_queue.size() > 0) begin
                i_valid <= 1;
                i_data_byte <= byte_queue[0].data;
                i_start_of_file <= byte_queue[0].sof;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // Receiver stall, including one long hold-off counted here.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1;
        end else if (!quiet_end && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_stall <= 1;
        end else begin
            i_stall <= 0;
        end
    end

    // Predict on accepted bytes and check accepted words at the rising edge.
    always @(posedge i_clk) begin
        t_pix e;
        in_taken = 0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected word: status %0d column %0d row %0d",
                           o_status, o_column, o_row);
                    errors++;
                end else begin
                    e = expected_pixels.pop_front();
                    pixels_seen++;
                    if (o_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, o_status); errors++;
                    end
                    if (o_red !== e.red) begin
                        $error("red: expected %0d, got %0d", e.red, o_red); errors++;
                    end
                    if (o_green !== e.green) begin
                        $error("green: expected %0d, got %0d", e.green, o_green); errors++;
                    end
                    if (o_blue !== e.blue) begin
                        $error("blue: expected %0d, got %0d", e.blue, o_blue); errors++;
                    end
                    if (o_column !== e.column) begin
                        $error("column: expected %0d, got %0d", e.column, o_column); errors++;
                    end
                    if (o_row !== e.row) begin
                        $error("row: expected %0d, got %0d", e.row, o_row); errors++;
                    end
                    if (o_last_pixel !== e.last) begin
                        $error("last_pixel: expected %0d, got %0d", e.last, o_last_pixel);
                        errors++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                predict_byte(byte_queue[0]);
                in_taken = 1;
            end
        end
    end

    task automatic wait_drained();
        while (byte_queue.size() != 0 || i_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int w, h;
        i_rst_n = 0;
        dec_phase = PH_IDLE; hdr_count = 0; shift_word = 0;
        img_w = 0; img_h = 0; img_len = 0; img_depth = 0; img_maptype = 0;
        img_maplen = 0; map_left = 0; col_cnt = 0; row_cnt = 0; pad_due = 0;
        repeat (3) @(posedge i_clk);
        #1 i_rst_n = 1;

        // Directed: idle noise, each error, odd/even widths, the full palette.
        add_byte(8'hff, 0); add_byte(8'h00, 0);
        add_word(32'h59a66a94, 1);
        add_word(srpd_pkg::RAS_MAGIC, 1); add_word(0, 0); add_word(1, 0); add_word(8, 0);
        add_word(0, 0); add_word(0, 0); add_word(0, 0); add_word(0, 0);
        add_file(32'h8000_0000, 1, 8, 0, 0, 0, 0);
        add_file(1, 1, 8, 32'h8000_0000, 0, 0, 0);
        add_file(2, 2, 2, 0, 0, 0, 0);
        add_file(3, 2, 1, 0, 0, 0, 8);
        add_file(2, 1, 32, 32'h7fff_ffff, 1, 5, 2);
        add_byte(8'h12, 0);
        add_file(2, 2, 24, 0, 1, 768, 4);
        for (int v = 0; v < 256; v += 51) add_byte(v, 0);
        add_byte(8'hff, 0);
        wait_drained();

        // Long receiver hold so the block backs up into its input.
        add_file(4, 12, 8, 0, 0, 0, 48);
        hold_left = 60;
        wait (hold_left == 0);
        wait_drained();

        // Sender pause: all results in before going on.
        add_file(3, 3, 8, 0, 0, 0, 12);
        repeat (12) @(posedge i_clk);
        sender_pause = 1;
        while (i_valid || expected_pixels.size() != 0) @(posedge i_clk);
        sender_pause = 0;
        wait_drained();

        while (items_queued < 1250) begin
            w = $urandom_range(1, 7); h = $urandom_range(1, 4);
            case ($urandom_range(0, 9))
                0: add_file(w, h, pick_depth(), 0, 1, 3, w * h + (w % 2) * h);
                1: add_file(w, h, $urandom_range(0, 40), 0, 0, 0, w * h + (w % 2) * h);
                2: begin
                    add_file(w, h, pick_depth(), 0, $urandom_range(0, 1),
                             $urandom_range(0, 6), $urandom_range(0, w * h));
                end
                3: add_byte($urandom, $urandom_range(0, 1));
                default: add_file(w, h, pick_depth(), $urandom_range(0, 100),
                                  $urandom_range(0, 1), $urandom_range(0, 9),
                                  w * h + (w % 2) * h);
            endcase
            if (items_queued > 1190) quiet_end = 1;
            while (byte_queue.size() > 200) @(posedge i_clk);
        end
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d files and %0d checked words, with stalls on both sides.",
                 files_sent, pixels_seen);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench NOT OK");
        $finish;
    end
endmodule
